>>> rtl/core/leg_pd_id_blend_torque_top_assert.svh
// assertion macros for the leg torque block
// used by the top level only, needs i_clk and i_rst_n in scope
`ifndef LEG_PD_ID_BLEND_TORQUE_TOP_ASSERT_SVH
`define LEG_PD_ID_BLEND_TORQUE_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define LPDID_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence a fixed number of cycles later
`define LPDID_ASSERT_LATER(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lpdid_pkg.sv
// shared constants, types and fixed-point helpers of the leg torque block
// no dependencies
`default_nettype none
package lpdid_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int Q_W             = 32;
    localparam int GAIN_W          = 31;
    localparam int FRAC_IN_W       = 17;
    localparam int ERR_W           = Q_W + 1;
    localparam int SINE_W          = FRAC_BITS + 1;
    localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);
    localparam int R_W             = SINE_TABLE_BITS - 1;
    localparam int SINE_SHIFT      = FRAC_BITS + 32 - SINE_TABLE_BITS;
    localparam int CFG_IDX_W       = 3;

    localparam logic signed [30:0] INV_TWO_PI_Q32 = 31'sd683565276;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [FRAC_IN_W-1:0] BLEND_ONE = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_D = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JOINT_P  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JOINT_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LINK     = 3'd7;

    typedef logic [SINE_W-1:0] t_sine_lut [QUARTER+1];

    typedef struct packed {
        logic [GAIN_W-1:0]       height_p;
        logic [GAIN_W-1:0]       height_d;
        logic [GAIN_W-1:0]       joint_p;
        logic [GAIN_W-1:0]       joint_d;
        logic [GAIN_W-1:0]       mass;
        logic signed [Q_W-1:0]   gravity;
        logic [GAIN_W-1:0]       limit;
        logic [GAIN_W-1:0]       link;
    } t_cfg;

    typedef struct packed {
        logic signed [Q_W-1:0]    pd_h;
        logic signed [Q_W-1:0]    pd_k;
        logic [FRAC_IN_W-1:0]     frac;
    } t_side;

    typedef struct packed {
        t_side                    side;
        logic signed [Q_W-1:0]    inner;
        logic signed [SINE_W:0]   s1;
        logic signed [SINE_W:0]   s12;
    } t_front_out;

    typedef struct packed {
        t_side                    side;
        logic signed [Q_W-1:0]    id_h;
        logic signed [Q_W-1:0]    id_k;
    } t_id_out;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[Q_W-1:0];
    endfunction

    // round half up to FRAC_BITS, then saturate
    function automatic logic signed [Q_W-1:0] mulq_rnd(input logic signed [65:0] p);
        logic signed [65:0] v;
        v = (p + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return sat32(v);
    endfunction

    // quarter-wave sine magnitudes, evaluated at elaboration
    function automatic t_sine_lut build_sine_lut();
        t_sine_lut lut;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int i = 0; i <= QUARTER; i++) begin
            x  = (64'(i) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
            x2 = (x * x) >> 30;
            t  = ONE_Q30 - x2 / 110;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            lut[i] = SINE_W'((s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
        end
        return lut;
    endfunction

    localparam t_sine_lut SINE_LUT = build_sine_lut();

    // signed sine from a turn index
    function automatic logic signed [SINE_W:0] sine_of(input logic [SINE_TABLE_BITS-1:0] idx);
        logic [R_W-1:0]          r;
        logic signed [SINE_W:0]  mag;
        r = {1'b0, idx[SINE_TABLE_BITS-3:0]};
        if (idx[SINE_TABLE_BITS-2]) begin
            r = R_W'(QUARTER) - r;
        end
        mag = $signed({1'b0, SINE_LUT[r]});
        return idx[SINE_TABLE_BITS-1] ? -mag : mag;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/lpdid_front.sv
// front pipeline: errors, gain products, PD sums, force term, sine lookups
// depends on lpdid_pkg
`default_nettype none
module lpdid_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire lpdid_pkg::t_cfg        i_cfg,
    input  wire logic [16:0]            i_blend_fraction,
    input  wire logic signed [31:0]     i_foot_height,
    input  wire logic signed [31:0]     i_hip_angle,
    input  wire logic signed [31:0]     i_knee_angle,
    input  wire logic signed [31:0]     i_foot_height_rate,
    input  wire logic signed [31:0]     i_hip_rate,
    input  wire logic signed [31:0]     i_knee_rate,
    input  wire logic signed [31:0]     i_target_height,
    input  wire logic signed [31:0]     i_target_height_rate,
    input  wire logic signed [31:0]     i_target_height_accel,
    input  wire logic [63:0]            i_target_joint_angles,
    input  wire logic [63:0]            i_target_joint_rates,
    output logic                        o_valid,
    output lpdid_pkg::t_front_out       o_data
);
    import lpdid_pkg::*;

    // stage 1: errors
    logic                     r1_v;
    logic signed [ERR_W-1:0]  r1_eh, r1_ek, r1_erh, r1_erk, r1_ez, r1_erz, r1_ang12;
    logic signed [Q_W-1:0]    r1_hip, r1_acc;
    logic [FRAC_IN_W-1:0]     r1_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_eh    <= ERR_W'($signed(i_target_joint_angles[31:0])) - ERR_W'(i_hip_angle);
        r1_ek    <= ERR_W'($signed(i_target_joint_angles[63:32])) - ERR_W'(i_knee_angle);
        r1_erh   <= ERR_W'($signed(i_target_joint_rates[31:0])) - ERR_W'(i_hip_rate);
        r1_erk   <= ERR_W'($signed(i_target_joint_rates[63:32])) - ERR_W'(i_knee_rate);
        r1_ez    <= ERR_W'(i_target_height) - ERR_W'(i_foot_height);
        r1_erz   <= ERR_W'(i_target_height_rate) - ERR_W'(i_foot_height_rate);
        r1_ang12 <= ERR_W'(i_hip_angle) + ERR_W'(i_knee_angle);
        r1_hip   <= i_hip_angle;
        r1_acc   <= i_target_height_accel;
        r1_frac  <= (i_blend_fraction > BLEND_ONE) ? BLEND_ONE : i_blend_fraction;
    end

    // stage 2: products
    logic                     r2_v;
    logic signed [64:0]       r2_ph, r2_pk, r2_prh, r2_prk, r2_pz, r2_prz;
    logic signed [63:0]       r2_a1, r2_a12;
    logic signed [Q_W-1:0]    r2_acc;
    logic [FRAC_IN_W-1:0]     r2_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_ph   <= $signed({1'b0, i_cfg.joint_p}) * r1_eh;
        r2_pk   <= $signed({1'b0, i_cfg.joint_p}) * r1_ek;
        r2_prh  <= $signed({1'b0, i_cfg.joint_d}) * r1_erh;
        r2_prk  <= $signed({1'b0, i_cfg.joint_d}) * r1_erk;
        r2_pz   <= $signed({1'b0, i_cfg.height_p}) * r1_ez;
        r2_prz  <= $signed({1'b0, i_cfg.height_d}) * r1_erz;
        r2_a1   <= r1_hip * INV_TWO_PI_Q32;
        r2_a12  <= r1_ang12 * INV_TWO_PI_Q32;
        r2_acc  <= r1_acc;
        r2_frac <= r1_frac;
    end

    // stage 3: rounding and turn index
    logic                     r3_v;
    logic signed [Q_W-1:0]    r3_mh, r3_mk, r3_mrh, r3_mrk, r3_mz, r3_mrz, r3_acc;
    logic [SINE_TABLE_BITS-1:0] r3_i1, r3_i12;
    logic [FRAC_IN_W-1:0]     r3_frac;
    logic signed [63:0]       n_a1, n_a12;

    always_comb begin
        n_a1  = r2_a1 + (64'sd1 <<< (SINE_SHIFT - 1));
        n_a12 = r2_a12 + (64'sd1 <<< (SINE_SHIFT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_mh   <= mulq_rnd(66'(r2_ph));
        r3_mk   <= mulq_rnd(66'(r2_pk));
        r3_mrh  <= mulq_rnd(66'(r2_prh));
        r3_mrk  <= mulq_rnd(66'(r2_prk));
        r3_mz   <= mulq_rnd(66'(r2_pz));
        r3_mrz  <= mulq_rnd(66'(r2_prz));
        r3_i1   <= n_a1[SINE_SHIFT+SINE_TABLE_BITS-1:SINE_SHIFT];
        r3_i12  <= n_a12[SINE_SHIFT+SINE_TABLE_BITS-1:SINE_SHIFT];
        r3_acc  <= r2_acc;
        r3_frac <= r2_frac;
    end

    // stage 4: sums and sine
    logic                     r4_v;
    t_front_out               r4_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_d.side.pd_h <= sat32(66'(r3_mh) + 66'(r3_mrh));
        r4_d.side.pd_k <= sat32(66'(r3_mk) + 66'(r3_mrk));
        r4_d.side.frac <= r3_frac;
        r4_d.inner     <= sat32(66'(r3_acc) + 66'(r3_mz) + 66'(r3_mrz) - 66'(i_cfg.gravity));
        r4_d.s1        <= sine_of(r3_i1);
        r4_d.s12       <= sine_of(r3_i12);
    end

    assign o_valid = r4_v;
    assign o_data  = r4_d;

endmodule
`default_nettype wire

>>> rtl/core/lpdid_id.sv
// inverse-dynamics pipeline: force, sine jacobian, joint torques
// depends on lpdid_pkg
`default_nettype none
module lpdid_id (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire lpdid_pkg::t_cfg        i_cfg,
    input  wire lpdid_pkg::t_front_out  i_data,
    output logic                        o_valid,
    output lpdid_pkg::t_id_out          o_data
);
    import lpdid_pkg::*;

    localparam int DEPTH = 5;

    // pd terms and fraction ride alongside
    logic [DEPTH-1:0]         r_v;
    t_side                    r_side [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DEPTH-2:0], i_valid};
        end
        r_side[0] <= i_data.side;
        for (int k = 1; k < DEPTH; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    logic signed [63:0]       r1_pm;
    logic signed [49:0]       r1_pl1, r1_pl12;
    logic signed [Q_W-1:0]    r2_force, r2_ml1, r2_ml12;
    logic signed [Q_W-1:0]    r3_force, r3_jh, r3_jk;
    logic signed [Q_W-1:0]    n_jk;
    logic signed [63:0]       r4_ph, r4_pk;
    logic signed [Q_W-1:0]    r5_idh, r5_idk;

    assign n_jk = sat32(-66'(r2_ml12));

    always_ff @(posedge i_clk) begin
        r1_pm    <= $signed({1'b0, i_cfg.mass}) * i_data.inner;
        r1_pl1   <= $signed({1'b0, i_cfg.link}) * i_data.s1;
        r1_pl12  <= $signed({1'b0, i_cfg.link}) * i_data.s12;
        r2_force <= mulq_rnd(66'(r1_pm));
        r2_ml1   <= mulq_rnd(66'(r1_pl1));
        r2_ml12  <= mulq_rnd(66'(r1_pl12));
        r3_force <= r2_force;
        r3_jk    <= n_jk;
        r3_jh    <= sat32(66'(n_jk) - 66'(r2_ml1));
        r4_ph    <= r3_jh * r3_force;
        r4_pk    <= r3_jk * r3_force;
        r5_idh   <= mulq_rnd(66'(r4_ph));
        r5_idk   <= mulq_rnd(66'(r4_pk));
    end

    assign o_valid     = r_v[DEPTH-1];
    assign o_data.side = r_side[DEPTH-1];
    assign o_data.id_h = r5_idh;
    assign o_data.id_k = r5_idk;

endmodule
`default_nettype wire

>>> rtl/core/lpdid_blend.sv
// blend of ID and PD torques, rounding and symmetric clamp, output register
// depends on lpdid_pkg
`default_nettype none
module lpdid_blend (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [30:0]            i_limit,
    input  wire lpdid_pkg::t_id_out     i_data,
    output logic                        o_valid,
    output logic signed [31:0]          o_hip_torque,
    output logic signed [31:0]          o_knee_torque,
    output logic                        o_hip_clamped,
    output logic                        o_knee_clamped
);
    import lpdid_pkg::*;

    logic                     r1_v;
    logic signed [49:0]       r1_ah, r1_bh, r1_ak, r1_bk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_ah <= $signed({1'b0, i_data.side.frac}) * i_data.id_h;
        r1_ak <= $signed({1'b0, i_data.side.frac}) * i_data.id_k;
        r1_bh <= $signed({1'b0, BLEND_ONE - i_data.side.frac}) * i_data.side.pd_h;
        r1_bk <= $signed({1'b0, BLEND_ONE - i_data.side.frac}) * i_data.side.pd_k;
    end

    logic signed [51:0]       n_vh, n_vk, n_lim;
    logic signed [31:0]       n_th, n_tk;
    logic                     n_fh, n_fk;

    always_comb begin
        n_lim = 52'($signed({1'b0, i_limit}));
        n_vh  = (52'(r1_ah) + 52'(r1_bh) + 52'sd32768) >>> 16;
        n_vk  = (52'(r1_ak) + 52'(r1_bk) + 52'sd32768) >>> 16;
        n_fh  = 1'b1;
        n_fk  = 1'b1;
        if (n_vh > n_lim) begin
            n_th = n_lim[31:0];
        end else if (n_vh < -n_lim) begin
            n_th = -n_lim[31:0];
        end else begin
            n_th = n_vh[31:0];
            n_fh = 1'b0;
        end
        if (n_vk > n_lim) begin
            n_tk = n_lim[31:0];
        end else if (n_vk < -n_lim) begin
            n_tk = -n_lim[31:0];
        end else begin
            n_tk = n_vk[31:0];
            n_fk = 1'b0;
        end
    end

    logic                     r2_v;
    logic signed [31:0]       r2_th, r2_tk;
    logic                     r2_fh, r2_fk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_th <= n_th;
        r2_tk <= n_tk;
        r2_fh <= n_fh;
        r2_fk <= n_fk;
    end

    assign o_valid        = r2_v;
    assign o_hip_torque   = r2_th;
    assign o_knee_torque  = r2_tk;
    assign o_hip_clamped  = r2_fh;
    assign o_knee_clamped = r2_fk;

endmodule
`default_nettype wire

>>> rtl/core/leg_pd_id_blend_torque_top.sv
// top level of the leg PD / inverse-dynamics torque blend: registers and pipeline
// depends on lpdid_pkg, lpdid_front, lpdid_id, lpdid_blend and the assert header
//
// channel   direction  handshake                 payload
// command   in         i_start, o_busy           fraction, measurements, targets
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
// result    out        o_done strobe             torques and clamp flags
//
// an item may start every cycle; its result shows on o_done after it passes through
// 4 front stages, 5 inverse-dynamics stages and 2 blend stages
// o_busy stays low and o_cfg_ready high: the pipeline never holds off
// synchronous active-low reset clears valid bits and loads register defaults
// the receiver cannot stall, so results leave on a fixed schedule
`default_nettype none
module leg_pd_id_blend_torque_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [16:0]        i_blend_fraction,
    input  wire logic signed [31:0] i_foot_height,
    input  wire logic signed [31:0] i_hip_angle,
    input  wire logic signed [31:0] i_knee_angle,
    input  wire logic signed [31:0] i_foot_height_rate,
    input  wire logic signed [31:0] i_hip_rate,
    input  wire logic signed [31:0] i_knee_rate,
    input  wire logic signed [31:0] i_target_height,
    input  wire logic signed [31:0] i_target_height_rate,
    input  wire logic signed [31:0] i_target_height_accel,
    input  wire logic [63:0]        i_target_joint_angles,
    input  wire logic [63:0]        i_target_joint_rates,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [lpdid_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    o_done,
    output logic signed [31:0]      o_hip_torque,
    output logic signed [31:0]      o_knee_torque,
    output logic                    o_hip_clamped,
    output logic                    o_knee_clamped
);
    import lpdid_pkg::*;
    `include "leg_pd_id_blend_torque_top_assert.svh"

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{link: 31'd15073, default: '0};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HEIGHT_P: r_cfg.height_p <= i_cfg_data[30:0];
                REG_HEIGHT_D: r_cfg.height_d <= i_cfg_data[30:0];
                REG_JOINT_P:  r_cfg.joint_p  <= i_cfg_data[30:0];
                REG_JOINT_D:  r_cfg.joint_d  <= i_cfg_data[30:0];
                REG_MASS:     r_cfg.mass     <= i_cfg_data[30:0];
                REG_GRAVITY:  r_cfg.gravity  <= $signed(i_cfg_data);
                REG_LIMIT:    r_cfg.limit    <= i_cfg_data[30:0];
                REG_LINK:     r_cfg.link     <= i_cfg_data[30:0];
                default:      r_cfg.link     <= r_cfg.link;
            endcase
        end
    end

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    logic        front_v, id_v;
    t_front_out  front_d;
    t_id_out     id_d;

    lpdid_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_start & ~o_busy),
        .i_cfg                 (r_cfg),
        .i_blend_fraction      (i_blend_fraction),
        .i_foot_height         (i_foot_height),
        .i_hip_angle           (i_hip_angle),
        .i_knee_angle          (i_knee_angle),
        .i_foot_height_rate    (i_foot_height_rate),
        .i_hip_rate            (i_hip_rate),
        .i_knee_rate           (i_knee_rate),
        .i_target_height       (i_target_height),
        .i_target_height_rate  (i_target_height_rate),
        .i_target_height_accel (i_target_height_accel),
        .i_target_joint_angles (i_target_joint_angles),
        .i_target_joint_rates  (i_target_joint_rates),
        .o_valid               (front_v),
        .o_data                (front_d)
    );

    lpdid_id u_id (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_v),
        .i_cfg   (r_cfg),
        .i_data  (front_d),
        .o_valid (id_v),
        .o_data  (id_d)
    );

    lpdid_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (id_v),
        .i_limit        (r_cfg.limit),
        .i_data         (id_d),
        .o_valid        (o_done),
        .o_hip_torque   (o_hip_torque),
        .o_knee_torque  (o_knee_torque),
        .o_hip_clamped  (o_hip_clamped),
        .o_knee_clamped (o_knee_clamped)
    );

    `LPDID_ASSERT_LATER(a_latency, i_start && !o_busy, 11, o_done, "item lost in pipeline")
    `LPDID_ASSERT_NOW(a_hip_flag, o_done && o_hip_clamped,
        o_hip_torque == $signed({1'b0, r_cfg.limit}) ||
        o_hip_torque == -$signed({1'b0, r_cfg.limit}), "hip flag without limit value")
    `LPDID_ASSERT_NOW(a_knee_range, o_done,
        o_knee_torque <= $signed({1'b0, r_cfg.limit}) &&
        o_knee_torque >= -$signed({1'b0, r_cfg.limit}), "knee torque beyond limit")

endmodule
`default_nettype wire
